// ===== hdl/rcol_pkg.sv =====
// rcol_pkg: widths, register indexes, link and state types for the resonant
// cascaded one-pole lowpass. No dependencies; the interfaces, the cell, the top level and the testbench use it.
`timescale 1ns / 1ps

package rcol_pkg;

    // Field and datapath widths
    localparam int SAMPLE_W   = 24;
    localparam int CH_W       = 5;
    localparam int CNT_W      = 6;
    localparam int GAIN_W     = 16;
    localparam int ACC_W      = 32;
    localparam int CH_DEPTH   = 2 ** CH_W;

    // Sizing of the design
    localparam int CHANNELS   = 32;
    localparam int MAX_STAGES = 32;
    localparam int REM_W      = $clog2(MAX_STAGES + 1);

    // Products: unsigned gain (zero-extended) times a signed word
    localparam int DIFF_W     = ACC_W + 1;
    localparam int CELL_P_W   = DIFF_W + GAIN_W + 1;
    localparam int RES_P_W    = ACC_W + GAIN_W + 1;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_STAGE_COUNT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STAGE_GAIN     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RESONANCE_GAIN = 2'd2;

    localparam logic [CNT_W-1:0]  STAGE_COUNT_RST = 6'd1;
    localparam logic [GAIN_W-1:0] STAGE_GAIN_RST  = 16'd32768;
    localparam logic [GAIN_W-1:0] RES_GAIN_RST    = 16'd0;

    // Data handed from one cell to the next
    typedef struct packed {
        logic                    valid;
        logic                    ch_ok;
        logic [CH_W-1:0]         ch;
        logic [REM_W-1:0]        rem;
        logic signed [ACC_W-1:0] x;
    } link_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FETCH,
        ST_INJECT,
        ST_RUN,
        ST_FINISH
    } state_t;

endpackage

// ===== hdl/rcol_if.sv =====
// rcol_if: valid/ready channel interfaces for input items and result items.
// Depends on rcol_pkg for field widths.
`timescale 1ns / 1ps

interface rcol_in_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [rcol_pkg::SAMPLE_W-1:0]   sample_in;
    logic [rcol_pkg::CH_W-1:0]              channel_in;

    modport source (output valid, output sample_in, output channel_in, input ready);
    modport sink   (input valid, input sample_in, input channel_in, output ready);
endinterface

interface rcol_out_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [rcol_pkg::SAMPLE_W-1:0]   sample_out;
    logic [rcol_pkg::CH_W-1:0]              channel_out;

    modport source (output valid, output sample_out, output channel_out, input ready);
    modport sink   (input valid, input sample_out, input channel_out, output ready);
endinterface

// ===== hdl/rcol_ram.sv =====
// rcol_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module rcol_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [$clog2(DEPTH)-1:0]   waddr,
    input  logic [WIDTH-1:0]           wdata,
    input  logic                       re,
    input  logic [$clog2(DEPTH)-1:0]   raddr,
    output logic [WIDTH-1:0]           rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/rcol_cell.sv =====
// rcol_cell: one one-pole stage of the cascade, holding that stage's state for
// every channel. Depends on rcol_pkg and rcol_ram.
`timescale 1ns / 1ps

module rcol_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          rd_en,
    input  logic [rcol_pkg::CH_W-1:0]     rd_addr,
    input  logic                          clr_en,
    input  logic [rcol_pkg::CH_W-1:0]     clr_addr,
    input  logic [rcol_pkg::GAIN_W-1:0]   gain,
    input  rcol_pkg::link_t               up_link,
    output rcol_pkg::link_t               down_link
);
    import rcol_pkg::*;

    logic [ACC_W-1:0]        rdata;
    logic                    ram_we;
    logic [CH_W-1:0]         ram_waddr;
    logic [ACC_W-1:0]        ram_wdata;
    logic signed [ACC_W-1:0] st;
    logic signed [DIFF_W-1:0] diff;
    logic signed [CELL_P_W-1:0] prod;
    logic signed [CELL_P_W-1:0] prod_sh;
    logic signed [ACC_W-1:0] st_new;
    logic                    active;
    logic                    down_vld_reg;
    logic                    down_vld_next;
    link_t                   down_pay_reg;
    link_t                   down_pay_next;

    // Stage state for every channel
    rcol_ram #(
        .WIDTH (ACC_W),
        .DEPTH (CH_DEPTH)
    ) u_state_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rdata)
    );

    // Clearing pass after reset takes the write port
    always_comb
    begin
        ram_we    = active || clr_en;
        ram_waddr = clr_en ? clr_addr : up_link.ch;
        ram_wdata = clr_en ? '0 : st_new;
    end

    assign st = $signed(rdata);

    // state += gain * (x - state), product floored by the gain scale
    always_comb
    begin
        active  = up_link.valid && up_link.ch_ok && (up_link.rem != '0);
        diff    = {up_link.x[ACC_W-1], up_link.x} - {st[ACC_W-1], st};
        prod    = $signed({1'b0, gain}) * diff;
        prod_sh = prod >>> GAIN_W;
        st_new  = st + prod_sh[ACC_W-1:0];
    end

    // Hand the item on: stage output when active, else pass x unchanged
    always_comb
    begin
        down_vld_next     = up_link.valid;
        down_pay_next     = up_link;
        down_pay_next.rem = (up_link.rem != '0) ? up_link.rem - 1'b1 : up_link.rem;
        down_pay_next.x   = active ? st_new : up_link.x;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            down_vld_reg <= 1'b0;
        end
        else
        begin
            down_vld_reg <= down_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        down_pay_reg <= down_pay_next;
    end

    always_comb
    begin
        down_link       = down_pay_reg;
        down_link.valid = down_vld_reg;
    end

endmodule

// ===== hdl/resonant_cascaded_onepole_lowpass.sv =====
// Resonant cascaded one-pole lowpass: top level with sequencer, resonance
// feedback, output scaling and the row of stage cells.
// An accepted item is held through fetch and inject, then walks all MAX_STAGES
// cells (one cell a cycle) and the output scaling registers; the block takes no
// new item until that item's result has been loaded into the output register.
// Reset: asynchronous, active low; feedback clears at once, stage state in a pass over every channel entry.
`timescale 1ns / 1ps

module resonant_cascaded_onepole_lowpass (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [rcol_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rcol_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    rcol_in_if.sink                          feed,
    rcol_out_if.source                       result
);
    import rcol_pkg::*;

    localparam logic signed [ACC_W+1:0] X_MAX = 34'sh0_7FFF_FFFF;
    localparam logic signed [ACC_W+1:0] X_MIN = -34'sh0_8000_0000;
    localparam logic signed [ACC_W+1:0] Y_MAX = 34'sh0_007F_FFFF;
    localparam logic signed [ACC_W+1:0] Y_MIN = -34'sh0_0080_0000;

    state_t state_reg, state_next;

    logic [CNT_W-1:0]           stage_count_reg;
    logic [GAIN_W-1:0]          stage_gain_reg;
    logic [GAIN_W-1:0]          res_gain_reg;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic [CH_W-1:0]            chan_reg;
    logic signed [ACC_W-1:0]    fb_reg [CH_DEPTH];
    logic signed [RES_P_W-1:0]  fb_prod_reg;
    logic signed [RES_P_W-1:0]  out_prod_reg;
    logic signed [ACC_W-1:0]    tail_x_reg;
    logic                       out_vld_reg;
    logic                       out_vld_next;
    logic signed [SAMPLE_W-1:0] out_sample_reg;
    logic [CH_W-1:0]            out_chan_reg;
    logic [CH_W-1:0]            clr_idx_reg;
    logic [CH_W-1:0]            clr_idx_next;

    logic                       accept;
    logic                       do_clear;
    logic                       do_fetch;
    logic                       do_inject;
    logic                       do_tail;
    logic                       do_load;
    logic                       out_free;
    logic                       ch_ok;
    logic [REM_W-1:0]           n_stages;
    logic signed [ACC_W+1:0]    front_sub;
    logic signed [ACC_W-1:0]    front_x;
    logic signed [ACC_W+1:0]    back_y;
    logic signed [ACC_W+1:0]    back_sh;
    logic signed [SAMPLE_W-1:0] back_sample;
    link_t                      chain [MAX_STAGES+1];

    assign accept   = feed.valid && feed.ready;
    assign out_free = !out_vld_reg || result.ready;
    assign ch_ok    = int'(chan_reg) < CHANNELS;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_count_reg <= STAGE_COUNT_RST;
            stage_gain_reg  <= STAGE_GAIN_RST;
            res_gain_reg    <= RES_GAIN_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_STAGE_COUNT:    stage_count_reg <= cfg_wdata[CNT_W-1:0];
                REG_STAGE_GAIN:     stage_gain_reg  <= cfg_wdata[GAIN_W-1:0];
                REG_RESONANCE_GAIN: res_gain_reg    <= cfg_wdata[GAIN_W-1:0];
                default:            ;
            endcase
        end
    end

    // Sequencer: next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:  if (clr_idx_reg == CH_W'(CH_DEPTH - 1)) state_next = ST_IDLE;
            ST_IDLE:   if (feed.valid) state_next = ST_FETCH;
            ST_FETCH:  state_next = ST_INJECT;
            ST_INJECT: state_next = ST_RUN;
            ST_RUN:    if (chain[MAX_STAGES].valid) state_next = ST_FINISH;
            ST_FINISH: if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Sequencer: outputs
    always_comb
    begin
        feed.ready = 1'b0;
        do_clear   = 1'b0;
        do_fetch   = 1'b0;
        do_inject  = 1'b0;
        do_tail    = 1'b0;
        do_load    = 1'b0;
        unique case (state_reg)
            ST_CLEAR:  do_clear   = 1'b1;
            ST_IDLE:   feed.ready = 1'b1;
            ST_FETCH:  do_fetch   = 1'b1;
            ST_INJECT: do_inject  = 1'b1;
            ST_RUN:    do_tail    = chain[MAX_STAGES].valid;
            ST_FINISH: do_load    = out_free;
            default:   ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Walk every channel entry once after reset
    always_comb
    begin
        clr_idx_next = do_clear ? clr_idx_reg + 1'b1 : clr_idx_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_idx_reg <= '0;
        end
        else
        begin
            clr_idx_reg <= clr_idx_next;
        end
    end

    // Hold the accepted item
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_reg <= feed.sample_in;
            chan_reg   <= feed.channel_in;
        end
    end

    // Resonance product from the channel's last cascade output
    always_ff @(posedge clk)
    begin
        if (do_fetch)
        begin
            fb_prod_reg <= $signed({1'b0, res_gain_reg}) * fb_reg[chan_reg];
        end
    end

    // Subtract feedback from the widened sample and saturate to Q1.31
    always_comb
    begin
        front_sub = {{2{sample_reg[SAMPLE_W-1]}}, sample_reg, 8'h00}
                  - {fb_prod_reg[RES_P_W-1], fb_prod_reg[RES_P_W-1:GAIN_W]};
        if (front_sub > X_MAX)
        begin
            front_x = X_MAX[ACC_W-1:0];
        end
        else if (front_sub < X_MIN)
        begin
            front_x = X_MIN[ACC_W-1:0];
        end
        else
        begin
            front_x = front_sub[ACC_W-1:0];
        end
        n_stages = (int'(stage_count_reg) > MAX_STAGES) ? REM_W'(MAX_STAGES)
                                                        : REM_W'(stage_count_reg);
    end

    // Inject the item at the head of the chain
    always_comb
    begin
        chain[0].valid = do_inject;
        chain[0].ch_ok = ch_ok;
        chain[0].ch    = chan_reg;
        chain[0].rem   = n_stages;
        chain[0].x     = front_x;
    end

    // Row of stage cells; all read their channel entry when the item arrives
    for (genvar k = 0; k < MAX_STAGES; k++)
    begin : g_cell
        rcol_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .rd_en     (accept),
            .rd_addr   (feed.channel_in),
            .clr_en    (do_clear),
            .clr_addr  (clr_idx_reg),
            .gain      (stage_gain_reg),
            .up_link   (chain[k]),
            .down_link (chain[k+1])
        );
    end

    // Store the cascade output as feedback
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CH_DEPTH; i++)
            begin
                fb_reg[i] <= '0;
            end
        end
        else if (do_tail && chain[MAX_STAGES].ch_ok)
        begin
            fb_reg[chain[MAX_STAGES].ch] <= chain[MAX_STAGES].x;
        end
    end

    // Output scaling product
    always_ff @(posedge clk)
    begin
        if (do_tail)
        begin
            tail_x_reg   <= chain[MAX_STAGES].x;
            out_prod_reg <= $signed({1'b0, res_gain_reg}) * $signed(chain[MAX_STAGES].x);
        end
    end

    // x + floor(x * resonance), drop to Q1.23 and saturate
    always_comb
    begin
        back_y  = {{2{tail_x_reg[ACC_W-1]}}, tail_x_reg}
                + {out_prod_reg[RES_P_W-1], out_prod_reg[RES_P_W-1:GAIN_W]};
        back_sh = back_y >>> 8;
        if (!ch_ok)
        begin
            back_sample = '0;
        end
        else if (back_sh > Y_MAX)
        begin
            back_sample = Y_MAX[SAMPLE_W-1:0];
        end
        else if (back_sh < Y_MIN)
        begin
            back_sample = Y_MIN[SAMPLE_W-1:0];
        end
        else
        begin
            back_sample = back_sh[SAMPLE_W-1:0];
        end
    end

    // Output register
    always_comb
    begin
        out_vld_next = do_load || (out_vld_reg && !result.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_load)
        begin
            out_sample_reg <= back_sample;
            out_chan_reg   <= chan_reg;
        end
    end

    assign result.valid       = out_vld_reg;
    assign result.sample_out  = out_sample_reg;
    assign result.channel_out = out_chan_reg;

endmodule

// ===== tb/tb_resonant_cascaded_onepole_lowpass.sv =====
// Testbench for the resonant cascaded one-pole lowpass: a per-channel cascade tracker
// predicts every filtered sample and checks the block's results in order.
// Depends on rcol_pkg, rcol_if and the top level resonant_cascaded_onepole_lowpass.
`timescale 1ns / 1ps

module tb_resonant_cascaded_onepole_lowpass;
    import rcol_pkg::*;

    localparam int     LATENCY     = 36;
    localparam int     CYCLE_LIMIT = 1000000;
    localparam int     PHASES      = 10;
    localparam int     PHASE_ITEMS = 55;
    localparam longint ACC_MAX     = (longint'(1) <<< (ACC_W - 1)) - 1;
    localparam longint ACC_MIN     = -(longint'(1) <<< (ACC_W - 1));
    localparam longint OUT_MAX     = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
    localparam longint OUT_MIN     = -(longint'(1) <<< (SAMPLE_W - 1));

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic [CH_W-1:0]            channel;
    } lp_result_t;

    // Per-channel cascade state, filter settings and the results still owed
    class lowpass_tracker;
        int                stage_state [CHANNELS][MAX_STAGES];
        int                feedback [CHANNELS];
        logic [CNT_W-1:0]  n_stages;
        logic [GAIN_W-1:0] stage_gain;
        logic [GAIN_W-1:0] res_gain;
        lp_result_t        pending_outputs [$];
        int                mismatches;

        function new();
            foreach (stage_state[c, k]) stage_state[c][k] = 0;
            foreach (feedback[c]) feedback[c] = 0;
            n_stages   = STAGE_COUNT_RST;
            stage_gain = STAGE_GAIN_RST;
            res_gain   = RES_GAIN_RST;
            mismatches = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_STAGE_COUNT:    n_stages   = data[CNT_W-1:0];
                REG_STAGE_GAIN:     stage_gain = data[GAIN_W-1:0];
                REG_RESONANCE_GAIN: res_gain   = data[GAIN_W-1:0];
                default: ;
            endcase
        endfunction

        // Run one accepted item through feedback, cascade and output scaling
        function void take_sample(logic signed [SAMPLE_W-1:0] s, logic [CH_W-1:0] ch);
            longint     x;
            longint     st;
            longint     y;
            int         n;
            lp_result_t r;
            r.channel = ch;
            r.sample  = '0;
            if (ch < CHANNELS) begin
                x = longint'(s) * 256;
                x = x - ((longint'(res_gain) * longint'(feedback[ch])) >>> 16);
                if (x > ACC_MAX) x = ACC_MAX;
                if (x < ACC_MIN) x = ACC_MIN;
                n = (n_stages > MAX_STAGES) ? MAX_STAGES : int'(n_stages);
                for (int k = 0; k < n; k++) begin
                    st = longint'(stage_state[ch][k]);
                    st = st + ((longint'(stage_gain) * (x - st)) >>> 16);
                    stage_state[ch][k] = int'(st);
                    x = st;
                end
                feedback[ch] = int'(x);
                y = x + ((x * longint'(res_gain)) >>> 16);
                y = y >>> 8;
                if (y > OUT_MAX) y = OUT_MAX;
                if (y < OUT_MIN) y = OUT_MIN;
                r.sample = y[SAMPLE_W-1:0];
            end
            pending_outputs.push_back(r);
        endfunction

        // Compare one accepted result with the oldest prediction
        function void match_output(logic signed [SAMPLE_W-1:0] s, logic [CH_W-1:0] ch);
            lp_result_t want;
            if (pending_outputs.size() == 0) begin
                $display("%0t: unexpected result, sample_out %0d channel_out %0d", $time, s, ch);
                mismatches++;
                return;
            end
            want = pending_outputs.pop_front();
            if (s !== want.sample) begin
                $display("%0t: sample_out mismatch: expected %0d, actual %0d",
                         $time, want.sample, s);
                mismatches++;
            end
            if (ch !== want.channel) begin
                $display("%0t: channel_out mismatch: expected %0d, actual %0d",
                         $time, want.channel, ch);
                mismatches++;
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    int                    cycle_count = 0;
    int                    stall_left  = 0;
    int                    steady_left = 0;
    lowpass_tracker        tracker;

    rcol_in_if  feed_if();
    rcol_out_if result_if();

    resonant_cascaded_onepole_lowpass u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .feed      (feed_if),
        .result    (result_if)
    );

    always #2 clk = ~clk;

    // Abort a run that hangs
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // Check accepted results, then stall the result side at random
    always @(posedge clk)
    begin
        if (rst_n && result_if.valid && result_if.ready)
            tracker.match_output(result_if.sample_out, result_if.channel_out);
        if (!rst_n)
            result_if.ready <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left--;
            result_if.ready <= 1'b0;
        end
        else
        begin
            int r;
            result_if.ready <= 1'b1;
            r = $urandom_range(0, 99);
            if (steady_left > 0)
                steady_left--;
            else if (r < 4)
                steady_left = $urandom_range(50, 300);
            else if (r < 75)
                ;
            else if (r < 95)
                stall_left = $urandom_range(1, 3);
            else
                stall_left = $urandom_range(20, 80);
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        int                         sel;
        logic signed [SAMPLE_W-1:0] v;
        sel = $urandom_range(0, 9);
        case (sel)
            0: v = SAMPLE_MAX;
            1: v = SAMPLE_MIN;
            2: v = SAMPLE_W'($urandom_range(0, 511) - 256);
            default: v = SAMPLE_W'($urandom);
        endcase
        return v;
    endfunction

    // Offer one item, hold it until taken, then idle for the given gap
    task automatic send_sample(logic signed [SAMPLE_W-1:0] s, logic [CH_W-1:0] ch, int gap);
        feed_if.valid      <= 1'b1;
        feed_if.sample_in  <= s;
        feed_if.channel_in <= ch;
        do @(posedge clk); while (!feed_if.ready);
        tracker.take_sample(s, ch);
        if (gap > 0)
        begin
            feed_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic hold_until_drained();
        feed_if.valid <= 1'b0;
        while (tracker.pending_outputs.size() != 0) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        tracker.write_reg(idx, data);
    endtask

    // Reprogram all three registers once the block has gone quiet
    task automatic program_filter(logic [CFG_DATA_W-1:0] count, logic [CFG_DATA_W-1:0] gain,
                                  logic [CFG_DATA_W-1:0] res);
        hold_until_drained();
        repeat (LATENCY) @(posedge clk);
        write_reg(REG_STAGE_COUNT, count);
        write_reg(REG_STAGE_GAIN, gain);
        write_reg(REG_RESONANCE_GAIN, res);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        int                         left;
        int                         len;
        int                         shape;
        bit                         no_gaps;
        bit                         paused_once;
        logic [CH_W-1:0]            ch;
        logic signed [SAMPLE_W-1:0] s;
        logic signed [SAMPLE_W-1:0] base;

        tracker            = new();
        paused_once        = 1'b0;
        clk                = 1'b0;
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = REG_STAGE_COUNT;
        cfg_wdata          = '0;
        feed_if.valid      = 1'b0;
        feed_if.sample_in  = '0;
        feed_if.channel_in = '0;
        result_if.ready    = 1'b0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: sample extremes, zero and minus one on the lowest and highest channels, then channel 5
        send_sample(SAMPLE_MAX, 0, 0);
        send_sample(SAMPLE_MIN, 0, 1);
        send_sample('0, 31, 0);
        send_sample(-1, 31, 2);
        send_sample(SAMPLE_MAX, 5, 0);

        // No stages: the feedback-corrected sample goes straight to output scaling
        program_filter(0, 40000, 30000);
        send_sample(SAMPLE_MAX, 3, 0);
        send_sample(SAMPLE_MIN, 3, 0);

        // Full cascade at the largest gains
        program_filter(32, 16'hFFFF, 16'd64880);
        send_sample(SAMPLE_MAX, 7, 0);
        send_sample(SAMPLE_MAX, 7, 0);
        send_sample(SAMPLE_MAX, 7, 3);
        send_sample(SAMPLE_MIN, 7, 0);

        // Stage count past the maximum, resonance past its usual ceiling
        program_filter(63, 1, 16'hFFFF);
        send_sample(SAMPLE_MIN, 7, 0);
        send_sample(SAMPLE_MAX, 9, 0);
        send_sample(SAMPLE_MIN, 9, 0);

        // Zero gain freezes the stages
        program_filter(2, 0, 0);
        send_sample(SAMPLE_MAX, 9, 0);
        send_sample(SAMPLE_MIN, 31, 0);

        // Random phases: bursts on a few channels so the cascade state builds up
        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0: program_filter(1, 16'hFFFF, 16'd64880);
                1: program_filter(32, 20000, 16'd64880);
                2: program_filter(0, CFG_DATA_W'($urandom_range(0, 65535)),
                                  CFG_DATA_W'($urandom_range(0, 64880)));
                3: program_filter(63, CFG_DATA_W'($urandom_range(0, 65535)), 16'hFFFF);
                4: program_filter(32, 1, 0);
                default: program_filter(CFG_DATA_W'($urandom_range(0, 63)),
                                        CFG_DATA_W'($urandom_range(0, 65535)),
                                        CFG_DATA_W'($urandom_range(0, 64880)));
            endcase
            left = PHASE_ITEMS;
            while (left > 0)
            begin
                ch = CH_W'(($urandom_range(0, 9) < 7) ? $urandom_range(0, 3)
                                                      : $urandom_range(0, 31));
                len = $urandom_range(1, 12);
                if (len > left) len = left;
                shape   = $urandom_range(0, 3);
                base    = pick_sample();
                no_gaps = ($urandom_range(0, 3) == 0);
                for (int j = 0; j < len; j++)
                begin
                    case (shape)
                        0: s = base;
                        1: s = pick_sample();
                        2: s = j[0] ? SAMPLE_MIN : SAMPLE_MAX;
                        default: s = (j == 0) ? base : '0;
                    endcase
                    send_sample(s, ch, no_gaps ? 0 : pick_gap());
                end
                left -= len;
                // After the first burst, and after later bursts at random, hold the feed until every result is back
                if (!paused_once || $urandom_range(0, 15) == 0)
                begin
                    hold_until_drained();
                    paused_once = 1'b1;
                end
            end
        end

        hold_until_drained();
        repeat (LATENCY + 4) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.pending_outputs.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
